>>> sv/bdll_pkg.sv
// ----------------------------------------------------------------------------
// bdll_pkg
// Shared types and constants of the bounded doubly linked list engine.
// ----------------------------------------------------------------------------
package bdll_pkg;

	localparam int NODES     = 16;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(NODES);
	localparam int CNT_W     = $clog2(NODES + 1);

	typedef enum logic [3:0] {
		REQ_INS_LAST   = 4'd0,
		REQ_INS_FIRST  = 4'd1,
		REQ_AFTER_IDX  = 4'd2,
		REQ_BEFORE_IDX = 4'd3,
		REQ_AFTER_VAL  = 4'd4,
		REQ_BEFORE_VAL = 4'd5,
		REQ_DEL_IDX    = 4'd6,
		REQ_DEL_VAL    = 4'd7,
		REQ_FIND       = 4'd8,
		REQ_GET        = 4'd9
	} req_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [31:0] insert_value;
		logic signed [31:0] key_value;
		logic [7:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               used_fallback;
		logic signed [31:0] result_value;
		logic [7:0]         result_position;
		logic [8:0]         list_count;
	} out_item_t;

	// token passed along the cell row during a search
	typedef struct packed {
		logic                 live;
		logic                 by_val;
		logic [7:0]           pos;
		logic [DATA_BITS-1:0] key;
	} probe_t;

	// answer of a cell that matched the probe
	typedef struct packed {
		logic                 hit;
		logic [7:0]           pos;
		logic [DATA_BITS-1:0] data;
	} hit_t;

endpackage

>>> sv/bounded_doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_engine_unit
// Ordered list of signed values in a fixed pool of NODES slots.
// ----------------------------------------------------------------------------
// The list is held in list order in a row of NODES cells, slot k holding
// element k; the links of the pool are implied by order. A request passes
// through a walk state in which a search probe walks the cell row one slot
// per cycle, an edit state that shifts the row to open or close a gap, and an
// output state in which the result beat is offered until it is taken; only
// then does the idle state take the next request.
module bounded_doubly_linked_list_engine_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bdll_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bdll_pkg::out_item_t  out_data
);

	localparam int N  = bdll_pkg::NODES;
	localparam int DW = bdll_pkg::DATA_BITS;
	localparam int IW = bdll_pkg::IDX_W;
	localparam int CW = bdll_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_EDIT  = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t               state_q;
	bdll_pkg::in_item_t   req_q;
	logic [CW-1:0]        count_q;
	logic [CW:0]          step_q;
	logic                 found_q;
	logic [7:0]           fpos_q;
	logic [DW-1:0]        fdata_q;
	bdll_pkg::out_item_t  res_q;

	bdll_pkg::probe_t     probe [N+1];
	bdll_pkg::hit_t       hits  [N];
	logic [DW-1:0]        cdata [N];
	logic                 load  [N];
	logic [DW-1:0]        ldata [N];

	logic [DW-1:0]        ins_d;
	logic [DW-1:0]        key_d;
	logic                 is_ins, is_val, want_after;
	logic [CW:0]          tgt;
	logic                 tgt_ok, full;

	assign ins_d = DW'(req_q.insert_value);
	assign key_d = DW'(req_q.key_value);
	assign is_ins = req_q.req_type <= 4'(bdll_pkg::REQ_BEFORE_VAL);
	assign is_val = req_q.req_type == 4'(bdll_pkg::REQ_AFTER_VAL)
		|| req_q.req_type == 4'(bdll_pkg::REQ_BEFORE_VAL)
		|| req_q.req_type == 4'(bdll_pkg::REQ_DEL_VAL)
		|| req_q.req_type == 4'(bdll_pkg::REQ_FIND);
	assign want_after = req_q.req_type == 4'(bdll_pkg::REQ_AFTER_IDX)
		|| req_q.req_type == 4'(bdll_pkg::REQ_AFTER_VAL);
	assign full = count_q == CW'(N);
	assign tgt_ok = is_val ? found_q : ({1'b0, req_q.position} < 9'(count_q));

	always_comb begin
		probe[0].live   = (state_q == S_WALK) && (step_q == '0);
		probe[0].by_val = 1'b1;
		probe[0].pos    = 8'd0;
		probe[0].key    = key_d;
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			bdll_pkg::probe_t pin;
			always_comb begin
				pin = probe[g];
				if (CW'(g) >= count_q) pin.live = 1'b0;
			end
			bdll_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.probe_in  (pin),
				.probe_out (probe[g+1]),
				.hit       (hits[g]),
				.load      (load[g]),
				.load_data (ldata[g]),
				.data_q    (cdata[g])
			);
		end
	endgenerate

	// first match wins: the probe reaches the slots in list order, slot k when step_q equals k
	logic          any_hit;
	logic [7:0]    hpos;
	logic [DW-1:0] hdata;
	always_comb begin
		any_hit = 1'b0;
		hpos    = '0;
		hdata   = '0;
		for (int k = 0; k < N; k++) begin
			if (hits[k].hit && step_q == (CW+1)'(k)) begin
				any_hit = 1'b1;
				hpos    = hits[k].pos;
				hdata   = hits[k].data;
			end
		end
	end

	// target slot index and row edit
	always_comb begin
		logic [CW:0] ins_at;
		logic        del;
		logic        ins;
		tgt = is_val ? (CW+1)'(fpos_q) : (CW+1)'(req_q.position);
		ins_at = '0;
		unique case (req_q.req_type)
			4'(bdll_pkg::REQ_INS_LAST):  ins_at = (CW+1)'(count_q);
			4'(bdll_pkg::REQ_INS_FIRST): ins_at = '0;
			default: begin
				if (!tgt_ok) ins_at = want_after ? (CW+1)'(count_q) : '0;
				else ins_at = want_after ? tgt + 1'b1 : tgt;
			end
		endcase
		ins = (state_q == S_EDIT) && is_ins && !full;
		del = (state_q == S_EDIT) && tgt_ok
			&& (req_q.req_type == 4'(bdll_pkg::REQ_DEL_IDX)
			|| req_q.req_type == 4'(bdll_pkg::REQ_DEL_VAL));
		for (int k = 0; k < N; k++) begin
			load[k]  = 1'b0;
			ldata[k] = cdata[k];
			if (ins && (CW+1)'(k) >= ins_at) begin
				load[k]  = 1'b1;
				ldata[k] = ((CW+1)'(k) == ins_at) ? ins_d : cdata[(k > 0) ? k - 1 : 0];
			end
			if (del && (CW+1)'(k) >= tgt && k < N - 1) begin
				load[k]  = 1'b1;
				ldata[k] = cdata[(k < N - 1) ? k + 1 : k];
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WALK;
						step_q  <= '0;
						found_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (any_hit && !found_q) found_q <= 1'b1;
					if (step_q == (CW+1)'(N)) state_q <= S_EDIT;
					else step_q <= step_q + 1'b1;
				end
				S_EDIT: begin
					state_q <= S_OUT;
					if (is_ins && !full) count_q <= count_q + 1'b1;
					else if (tgt_ok && (req_q.req_type == 4'(bdll_pkg::REQ_DEL_IDX)
						|| req_q.req_type == 4'(bdll_pkg::REQ_DEL_VAL)))
						count_q <= count_q - 1'b1;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// probe chain delays key; re-inject the held key after acceptance
	// by relying on walk hits computed against registered req key below
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) req_q <= in_data;
		if (state_q == S_WALK && any_hit && !found_q) begin
			fpos_q  <= hpos;
			fdata_q <= hdata;
		end
		if (state_q == S_EDIT) begin
			res_q.status          <= bdll_pkg::ST_OK;
			res_q.used_fallback   <= 1'b0;
			res_q.result_value    <= '0;
			res_q.result_position <= '0;
			res_q.list_count      <= 9'(count_q);
			if (is_ins) begin
				if (full) res_q.status <= bdll_pkg::ST_FULL;
				else begin
					res_q.list_count <= 9'(count_q) + 9'd1;
					res_q.used_fallback <= req_q.req_type > 4'(bdll_pkg::REQ_INS_FIRST)
						&& !tgt_ok;
				end
			end else if (req_q.req_type <= 4'(bdll_pkg::REQ_GET)) begin
				if (!tgt_ok) res_q.status <= bdll_pkg::ST_MISS;
				else begin
					res_q.result_value <= 32'(signed'(is_val ? fdata_q
						: cdata[tgt[IW-1:0]]));
					if (is_val && req_q.req_type != 4'(bdll_pkg::REQ_DEL_VAL)
						|| req_q.req_type == 4'(bdll_pkg::REQ_DEL_VAL))
						res_q.result_position <= fpos_q;
					if (!is_val) res_q.result_position <= '0;
					if (req_q.req_type == 4'(bdll_pkg::REQ_DEL_IDX)
						|| req_q.req_type == 4'(bdll_pkg::REQ_DEL_VAL))
						res_q.list_count <= 9'(count_q) - 9'd1;
				end
			end
		end
	end

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N)) else $error("count overflow");
	a_out_after_edit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_EDIT)) else $error("result without edit");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
`endif

endmodule

>>> sv/bdll_cell.sv
// ----------------------------------------------------------------------------
// bdll_cell
// One list slot: holds a value, passes the search probe to the next slot every
// cycle with its position count raised by one, and reports a match by value.
// ----------------------------------------------------------------------------
module bdll_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdll_pkg::probe_t              probe_in,
	output bdll_pkg::probe_t              probe_out,
	output bdll_pkg::hit_t                hit,
	input  logic                          load,
	input  logic [bdll_pkg::DATA_BITS-1:0] load_data,
	output logic [bdll_pkg::DATA_BITS-1:0] data_q
);

	bdll_pkg::probe_t probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.live   <= probe_in.live;
			probe_q.by_val <= probe_in.by_val;
			probe_q.key    <= probe_in.key;
			probe_q.pos    <= probe_in.pos + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign probe_out = probe_q;

	always_comb begin
		hit.pos  = probe_in.pos;
		hit.data = data_q;
		hit.hit  = probe_in.live && (probe_in.by_val ? (data_q == probe_in.key) : 1'b0);
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bounded doubly linked list engine. An array predictor holds
// the list in order and forecasts each result beat; a scoreboard class checks
// every accepted result field by field. Random idling on both sides, a long
// receiver hold-off and a drain pause exercise the handshake.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	class list_scoreboard;
		bdll_pkg::out_item_t pending[$];
		int        errors;
		logic signed [31:0] vals[$];

		function new();
			errors = 0;
		endfunction

		function int locate(logic signed [31:0] k);
			foreach (vals[i]) if (vals[i] == k) return i;
			return -1;
		endfunction

		function void note_request(bdll_pkg::in_item_t it);
			bdll_pkg::out_item_t r;
			int        t;
			logic [3:0] q;
			q = it.req_type;
			r = '0;
			if (q <= bdll_pkg::REQ_BEFORE_VAL) begin
				if (vals.size() >= bdll_pkg::NODES) begin
					r.status = bdll_pkg::ST_FULL;
				end else begin
					t = -1;
					if (q == bdll_pkg::REQ_AFTER_IDX || q == bdll_pkg::REQ_BEFORE_IDX)
						t = (it.position < vals.size()) ? int'(it.position) : -1;
					else if (q == bdll_pkg::REQ_AFTER_VAL || q == bdll_pkg::REQ_BEFORE_VAL)
						t = locate(it.key_value);
					if (q == bdll_pkg::REQ_INS_LAST) vals.push_back(it.insert_value);
					else if (q == bdll_pkg::REQ_INS_FIRST) vals.push_front(it.insert_value);
					else if (t < 0) begin
						r.used_fallback = 1'b1;
						if (q == bdll_pkg::REQ_AFTER_IDX || q == bdll_pkg::REQ_AFTER_VAL)
							vals.push_back(it.insert_value);
						else
							vals.push_front(it.insert_value);
					end else if (q == bdll_pkg::REQ_AFTER_IDX || q == bdll_pkg::REQ_AFTER_VAL)
						vals.insert(t + 1, it.insert_value);
					else
						vals.insert(t, it.insert_value);
				end
			end else if (q <= bdll_pkg::REQ_GET) begin
				if (q == bdll_pkg::REQ_DEL_IDX || q == bdll_pkg::REQ_GET)
					t = (it.position < vals.size()) ? int'(it.position) : -1;
				else
					t = locate(it.key_value);
				if (t < 0) begin
					r.status = bdll_pkg::ST_MISS;
				end else begin
					r.result_value = vals[t];
					if (q == bdll_pkg::REQ_DEL_VAL || q == bdll_pkg::REQ_FIND)
						r.result_position = t[7:0];
					if (q == bdll_pkg::REQ_DEL_IDX || q == bdll_pkg::REQ_DEL_VAL)
						vals.delete(t);
				end
			end
			r.list_count = 9'(vals.size());
			pending.push_back(r);
		endfunction

		function void check_result(bdll_pkg::out_item_t got);
			bdll_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.used_fallback !== e.used_fallback) begin
				$display("%0t: used_fallback exp %0d got %0d", $time, e.used_fallback,
					got.used_fallback);
				errors++;
			end
			if (got.result_value !== e.result_value) begin
				$display("%0t: result_value exp %0d got %0d", $time, e.result_value,
					got.result_value);
				errors++;
			end
			if (got.result_position !== e.result_position) begin
				$display("%0t: result_position exp %0d got %0d", $time, e.result_position,
					got.result_position);
				errors++;
			end
			if (got.list_count !== e.list_count) begin
				$display("%0t: list_count exp %0d got %0d", $time, e.list_count,
					got.list_count);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	bdll_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	bdll_pkg::out_item_t out_data;

	list_scoreboard sb = new();
	bit  calm = 1'b0;
	bit  hold_rx = 1'b0;
	int  idle_cycles = 0;
	int  sent = 0;
	int  got = 0;
	int  miss_seen = 0;
	int  full_seen = 0;
	int  fb_seen = 0;

	bounded_doubly_linked_list_engine_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_request(in_data);
		if (out_valid && out_ready) begin
			sb.check_result(out_data);
			got++;
			if (out_data.status == bdll_pkg::ST_MISS) miss_seen++;
			if (out_data.status == bdll_pkg::ST_FULL) full_seen++;
			if (out_data.used_fallback) fb_seen++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("bounded_doubly_linked_list_engine_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || hold_rx) out_ready <= 1'b0;
		else if (calm) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= 29);
	end

	task automatic send_beat(bdll_pkg::in_item_t it);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_req(logic [3:0] q, logic [31:0] iv, logic [31:0] kv,
		logic [7:0] p);
		bdll_pkg::in_item_t it;
		it.req_type = q;
		it.insert_value = iv;
		it.key_value = kv;
		it.position = p;
		send_beat(it);
	endtask

	function automatic logic [31:0] pick_value();
		int s;
		s = $urandom_range(9);
		if (s == 0) return 32'h8000_0000;
		if (s == 1) return 32'h7fff_ffff;
		if (s == 2) return $urandom();
		return $urandom_range(7) - 3;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_req(int bias);
		logic [3:0] q;
		logic [7:0] p;
		int r;
		r = $urandom_range(99);
		if (r < 2) q = 4'd10 + 4'($urandom_range(5));
		else if (r < bias) q = 4'($urandom_range(5));
		else q = 4'($urandom_range(9));
		p = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(17));
		send_req(q, pick_value(), pick_value(), p);
	endtask

	initial begin
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(bdll_pkg::REQ_GET, 0, 0, 0);
		send_req(bdll_pkg::REQ_DEL_IDX, 0, 0, 0);
		send_req(bdll_pkg::REQ_DEL_VAL, 0, 5, 0);
		send_req(bdll_pkg::REQ_FIND, 0, 5, 0);
		send_req(bdll_pkg::REQ_AFTER_IDX, 32'h7fff_ffff, 0, 8'd255);
		send_req(bdll_pkg::REQ_BEFORE_VAL, 32'h8000_0000, 1, 0);
		send_req(bdll_pkg::REQ_INS_LAST, 32'hffff_ffff, 0, 0);
		send_req(bdll_pkg::REQ_INS_FIRST, 32'd1, 0, 0);
		send_req(bdll_pkg::REQ_AFTER_IDX, 32'd2, 0, 8'd3);
		send_req(bdll_pkg::REQ_BEFORE_IDX, 32'd3, 0, 8'd0);
		send_req(bdll_pkg::REQ_AFTER_VAL, 32'd4, 32'h7fff_ffff, 0);
		send_req(bdll_pkg::REQ_BEFORE_VAL, 32'd5, 32'hffff_ffff, 0);
		send_req(bdll_pkg::REQ_AFTER_IDX, 32'd6, 0, 8'd5);
		send_req(bdll_pkg::REQ_FIND, 0, 32'h8000_0000, 0);
		send_req(bdll_pkg::REQ_GET, 0, 0, 8'd2);
		send_req(4'd15, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
		send_req(bdll_pkg::REQ_DEL_VAL, 0, 32'd6, 0);
		send_req(bdll_pkg::REQ_DEL_IDX, 0, 0, 8'd0);
		for (i = 0; i < 14; i++) send_req(bdll_pkg::REQ_INS_LAST, i, 0, 0);
		send_req(bdll_pkg::REQ_AFTER_VAL, 32'd9, 32'd3, 0);
		send_req(bdll_pkg::REQ_GET, 0, 0, 8'd15);
		drain();

		calm = 1'b1;
		for (i = 0; i < 150; i++) random_req(45);
		calm = 1'b0;

		fork
			begin
				hold_rx = 1'b1;
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (i = 0; i < 12; i++) random_req(50);
		join

		drain();
		repeat (40) @(posedge clk);

		for (i = 0; i < 1050; i++) random_req((i / 150) % 2 ? 70 : 35);

		drain();
		repeat (60) @(posedge clk);
		$display("%0d requests sent, %0d results checked", sent, got);
		$display("misses %0d, full refusals %0d, fallbacks %0d", miss_seen, full_seen,
			fb_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("bounded_doubly_linked_list_engine_unit verification clean");
		else
			$display("bounded_doubly_linked_list_engine_unit verification failed");
		$finish;
	end
endmodule

>>> bounded_doubly_linked_list_engine_unit.f
sv/bdll_pkg.sv
sv/bdll_cell.sv
sv/bounded_doubly_linked_list_engine_unit.sv
test/tb_top.sv
